// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, masked while reset is high
`define CCFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset
`define CCFD_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ccfd_pkg.sv =====
// Types, codes and the byte-wide CRC-16 step for the frame deframer
package ccfd_pkg;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_FRAME_BYTE  = 3'd0,
      KIND_FRAME_GOOD  = 3'd1,
      KIND_BAD_MAGIC   = 3'd2,
      KIND_BAD_VERSION = 3'd3,
      KIND_BAD_CRC     = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_MAGIC2  = 4'd1,
      PH_VERSION = 4'd2,
      PH_SEQ     = 4'd3,
      PH_TYPE    = 4'd4,
      PH_LEN     = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CRC_LO  = 4'd7,
      PH_CRC_HI  = 4'd8
   } phase_type;

   localparam logic [2:0] REG_MAGIC_FIRST  = 3'd0;
   localparam logic [2:0] REG_MAGIC_SECOND = 3'd1;
   localparam logic [2:0] REG_VERSION      = 3'd2;
   localparam logic [2:0] REG_CRC_POLY     = 3'd3;
   localparam logic [2:0] REG_CRC_INIT     = 3'd4;
   localparam logic [2:0] REG_CRC_REFLECT  = 3'd5;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [7:0]  expected_version;
      logic [15:0] crc_polynomial;
      logic [15:0] crc_initial;
      logic        crc_reflected;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic [8:0] byte_position;
      logic [7:0] sequence_number;
      logic [8:0] frame_length;
      logic       last;
   } result_type;

   // Results produced by one accepted byte: zero, one or two
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // One byte through the CRC-16, eight bit steps unrolled
   function automatic logic [15:0] crc_feed(input logic [15:0] acc_in,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly,
                                            input logic        reflected);
      logic [15:0] acc;
      logic [15:0] rpoly;
      int          i;
      for (i = 0; i < 16; i++) begin
         rpoly[15 - i] = poly[i];
      end
      if (reflected) begin
         acc = acc_in ^ {8'h00, data};
         for (i = 0; i < 8; i++) begin
            acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
         end
      end else begin
         acc = acc_in ^ {data, 8'h00};
         for (i = 0; i < 8; i++) begin
            acc = acc[15] ? ((acc << 1) ^ poly) : (acc << 1);
         end
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/crc_checked_frame_deframer.sv =====
// Top level of the CRC-checked frame deframer
//
// Usage: received bytes enter one per beat on the req_ channel. The block
// hunts for the two start bytes, checks the version, then takes sequence,
// type, length, payload and a little-endian CRC-16. Every byte taken into a
// frame comes out on the rsp_ channel as a frame-byte beat with its position;
// a verdict beat (frame good, bad magic, bad version, bad CRC) follows.
// rsp_last marks the final result beat caused by one input byte.
// Throughput: one byte per cycle while req_stall is low; the parse step and
// the byte-wide CRC (eight unrolled bit steps) sit between the parse
// registers and a four-entry result queue, whose head drives rsp_. A byte
// that yields two results needs two output beats, so long runs of such
// bytes go at the rsp_ drain rate.
// Stall: req_stall rises while the queue has room for fewer than two
// results; a stalled rsp_ beat holds its payload.
// Reset (synchronous): parser back to hunting, queue emptied, registers to
// their defaults. CRC polynomial, initial value and bit order are set over
// the APB-style port; write them only while the block is idle.
module crc_checked_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [8:0]  rsp_byte_position,
   output logic [7:0]  rsp_sequence_number,
   output logic [8:0]  rsp_frame_length,
   output logic        rsp_last,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ccfd_pkg::*;

   cfg_type    cfg;
   push_type   push;
   result_type head;
   logic       fire;
   logic       pop;
   logic       not_empty;
   logic       room_for_two;

   // a byte is only taken when both of its possible results fit
   assign req_stall = ~room_for_two;
   assign fire      = req_valid & room_for_two;

   assign rsp_valid = not_empty;
   assign pop       = not_empty & ~rsp_stall;

   assign rsp_kind            = head.kind;
   assign rsp_byte_value      = head.byte_value;
   assign rsp_byte_position   = head.byte_position;
   assign rsp_sequence_number = head.sequence_number;
   assign rsp_frame_length    = head.frame_length;
   assign rsp_last            = head.last;

   ccfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ccfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .push    (push)
   );

   ccfd_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (pop),
      .not_empty    (not_empty),
      .room_for_two (room_for_two),
      .head         (head)
   );

endmodule

// ===== hw/rtl/ccfd_csr.sv =====
// Configuration registers behind the APB-style port
module ccfd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output ccfd_pkg::cfg_type cfg
);
   import ccfd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[4:2];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_MAGIC_FIRST:  cfg_in.magic_first      = pwdata[7:0];
            REG_MAGIC_SECOND: cfg_in.magic_second     = pwdata[7:0];
            REG_VERSION:      cfg_in.expected_version = pwdata[7:0];
            REG_CRC_POLY:     cfg_in.crc_polynomial   = pwdata[15:0];
            REG_CRC_INIT:     cfg_in.crc_initial      = pwdata[15:0];
            REG_CRC_REFLECT:  cfg_in.crc_reflected    = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAGIC_FIRST:  prdata = {24'h0, cfg_ff.magic_first};
         REG_MAGIC_SECOND: prdata = {24'h0, cfg_ff.magic_second};
         REG_VERSION:      prdata = {24'h0, cfg_ff.expected_version};
         REG_CRC_POLY:     prdata = {16'h0, cfg_ff.crc_polynomial};
         REG_CRC_INIT:     prdata = {16'h0, cfg_ff.crc_initial};
         REG_CRC_REFLECT:  prdata = {31'h0, cfg_ff.crc_reflected};
         default:          prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first      <= 8'd170;
         cfg_ff.magic_second     <= 8'd85;
         cfg_ff.expected_version <= 8'd1;
         cfg_ff.crc_polynomial   <= 16'h1021;
         cfg_ff.crc_initial      <= 16'hFFFF;
         cfg_ff.crc_reflected    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/ccfd_parser.sv =====
// Frame parse state machine with incremental CRC-16
module ccfd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  ccfd_pkg::cfg_type cfg,
   output ccfd_pkg::push_type push
);
   import ccfd_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [8:0]  pos_ff,    pos_in;
   logic [7:0]  pcount_ff, pcount_in;
   logic [7:0]  plen_ff,   plen_in;
   logic [7:0]  seq_ff,    seq_in;
   logic [15:0] crc_ff,    crc_in;
   logic [7:0]  crclo_ff,  crclo_in;

   logic        is_m1, is_m2, is_ver, crc_ok;
   logic [15:0] crc_next;
   logic [7:0]  pcount_inc;
   logic [8:0]  pos_inc;
   result_type  echo_cur, echo_zero, verdict;
   result_type  res0, res1;
   logic [1:0]  n_res;

   assign is_m1      = (rx_byte == cfg.magic_first);
   assign is_m2      = (rx_byte == cfg.magic_second);
   assign is_ver     = (rx_byte == cfg.expected_version);
   assign crc_ok     = ({rx_byte, crclo_ff} == crc_ff);
   assign crc_next   = crc_feed(crc_ff, rx_byte, cfg.crc_polynomial, cfg.crc_reflected);
   assign pcount_inc = pcount_ff + 8'd1;
   assign pos_inc    = pos_ff + 9'd1;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_inc;
      pcount_in = pcount_ff;
      plen_in   = plen_ff;
      seq_in    = seq_ff;
      crc_in    = crc_ff;
      crclo_in  = crclo_ff;
      case (phase_ff)
         PH_MAGIC2: begin
            if (is_m2) begin
               phase_in = PH_VERSION;
            end else begin
               pcount_in = 8'd0;
               if (is_m1) begin
                  pos_in   = 9'd1;
                  crc_in   = cfg.crc_initial;
                  phase_in = PH_MAGIC2;
               end else begin
                  pos_in   = 9'd0;
                  phase_in = PH_HUNT;
               end
            end
         end
         PH_VERSION: begin
            if (is_ver) begin
               crc_in   = crc_next;
               phase_in = PH_SEQ;
            end else begin
               pos_in    = 9'd0;
               pcount_in = 8'd0;
               phase_in  = PH_HUNT;
            end
         end
         PH_SEQ: begin
            seq_in   = rx_byte;
            crc_in   = crc_next;
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            crc_in   = crc_next;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            plen_in   = rx_byte;
            crc_in    = crc_next;
            pcount_in = 8'd0;
            phase_in  = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            crc_in    = crc_next;
            pcount_in = pcount_inc;
            if (pcount_inc >= plen_ff) phase_in = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crclo_in = rx_byte;
            phase_in = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            pos_in    = 9'd0;
            pcount_in = 8'd0;
            phase_in  = PH_HUNT;
         end
         default: begin
            // hunting, unused codes included
            phase_in = PH_HUNT;
            pos_in   = pos_ff;
            if (is_m1) begin
               pos_in   = 9'd1;
               crc_in   = cfg.crc_initial;
               phase_in = PH_MAGIC2;
            end
         end
      endcase
   end

   // result items
   always_comb begin
      echo_cur               = '0;
      echo_cur.kind          = KIND_FRAME_BYTE;
      echo_cur.byte_value    = rx_byte;
      echo_cur.byte_position = pos_ff;
      echo_zero               = echo_cur;
      echo_zero.byte_position = 9'd0;
      verdict = '0;
      if (crc_ok) begin
         verdict.kind         = KIND_FRAME_GOOD;
         verdict.frame_length = {1'b0, plen_ff} + 9'd8;
      end else begin
         verdict.kind            = KIND_BAD_CRC;
         verdict.sequence_number = seq_ff;
      end
      res0  = echo_cur;
      res1  = '0;
      n_res = 2'd1;
      case (phase_ff)
         PH_MAGIC2: begin
            if (!is_m2) begin
               res0      = '0;
               res0.kind = KIND_BAD_MAGIC;
               if (is_m1) begin
                  res1  = echo_zero;
                  n_res = 2'd2;
               end
            end
         end
         PH_VERSION: begin
            if (!is_ver) begin
               res1.kind = KIND_BAD_VERSION;
               n_res     = 2'd2;
            end
         end
         PH_SEQ, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CRC_LO: begin
            n_res = 2'd1;
         end
         PH_CRC_HI: begin
            res1  = verdict;
            n_res = 2'd2;
         end
         default: begin
            res0  = echo_zero;
            n_res = is_m1 ? 2'd1 : 2'd0;
         end
      endcase
      res0.last = (n_res == 2'd1);
      res1.last = 1'b1;
   end

   assign push.count  = fire ? n_res : 2'd0;
   assign push.first  = res0;
   assign push.second = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         pos_ff    <= 9'd0;
         pcount_ff <= 8'd0;
         plen_ff   <= 8'd0;
         seq_ff    <= 8'd0;
         crc_ff    <= 16'hFFFF;
         crclo_ff  <= 8'd0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         pcount_ff <= pcount_in;
         plen_ff   <= plen_in;
         seq_ff    <= seq_in;
         crc_ff    <= crc_in;
         crclo_ff  <= crclo_in;
      end
   end

`include "assert_macros.svh"

   `CCFD_ASSERT(a_frame_end_rehunt, clock, reset, (fire && phase_ff == PH_CRC_HI) |=> (phase_ff == PH_HUNT && pos_ff == 9'd0), "parser did not return to hunt after CRC high byte")
   `CCFD_NEVER(a_last_on_first, clock, reset, (push.count == 2'd2 && push.first.last), "last set on first of two results")

endmodule

// ===== hw/rtl/ccfd_rsp_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one
module ccfd_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  ccfd_pkg::push_type  push,
   input  logic                pop,
   output logic                not_empty,
   output logic                room_for_two,
   output ccfd_pkg::result_type head
);
   import ccfd_pkg::*;

   result_type entry_ff [QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff,  count_in;
   logic [1:0] wr_ptr_nx;

   assign wr_ptr_nx    = wr_ptr_ff + 2'd1;
   assign not_empty    = (count_ff != 3'd0);
   assign room_for_two = (count_ff <= 3'(QUEUE_DEPTH - 2));
   assign head         = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_ptr_nx] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`include "assert_macros.svh"

   `CCFD_NEVER(a_overflow, clock, reset, ({1'b0, count_ff} + {2'b00, push.count} > 4'(QUEUE_DEPTH)), "result queue overflow")
   `CCFD_NEVER(a_underflow, clock, reset, (pop && count_ff == 3'd0), "result queue pop while empty")
   `CCFD_ASSERT(a_idle_stays_empty, clock, reset, (count_ff == 3'd0 && push.count == 2'd0) |=> (count_ff == 3'd0), "queue filled with no push")

endmodule
